// File: rtl/jtl_pkg.sv
// ----------------------------------------------------------------------------
// jtl_pkg
// Shared types, constants and character-class helpers for the JSON lexer.
// ----------------------------------------------------------------------------
package jtl_pkg;

  localparam int unsigned MAX_DOC_BYTES_DEF = 65536;

  // Most tokens a single byte can complete (number, punctuation, end)
  localparam int unsigned MAX_RES = 3;
  // Result queue depth; input is taken while at most this many slots minus MAX_RES are full
  localparam int unsigned QDEPTH  = 4;

  typedef enum logic [3:0] {
    KIND_LBRACE   = 4'd0,
    KIND_RBRACE   = 4'd1,
    KIND_LBRACKET = 4'd2,
    KIND_RBRACKET = 4'd3,
    KIND_COLON    = 4'd4,
    KIND_COMMA    = 4'd5,
    KIND_TRUE     = 4'd6,
    KIND_FALSE    = 4'd7,
    KIND_NULL     = 4'd8,
    KIND_NUMBER   = 4'd9,
    KIND_STRING   = 4'd10,
    KIND_END      = 4'd11,
    KIND_ERROR    = 4'd12
  } kind_t;

  typedef enum logic [9:0] {
    M_IDLE = 10'b00_0000_0001,
    M_INT  = 10'b00_0000_0010,
    M_DOT  = 10'b00_0000_0100,
    M_FRAC = 10'b00_0000_1000,
    M_EXP  = 10'b00_0001_0000,
    M_EXPD = 10'b00_0010_0000,
    M_KW   = 10'b00_0100_0000,
    M_STR  = 10'b00_1000_0000,
    M_ESC  = 10'b01_0000_0000,
    M_HEX  = 10'b10_0000_0000
  } lex_mode_t;

  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  typedef struct packed {
    lex_mode_t  mode;
    logic [1:0] kw_id;
    logic [2:0] kw_matched;
    logic [2:0] hex_left;
    logic       discarding;
  } lex_state_t;

  localparam lex_state_t LEX_STATE_RST = '{
    mode:       M_IDLE,
    kw_id:      2'd0,
    kw_matched: 3'd0,
    hex_left:   3'd0,
    discarding: 1'b0
  };

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_simple_escape(input logic [7:0] c);
    return (c == "\"") || (c == "\\") || (c == "/") || (c == "b") ||
           (c == "f") || (c == "n") || (c == "r") || (c == "t");
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] id);
    logic [2:0] len;
    len = (id == KW_FALSE) ? 3'd5 : 3'd4;
    return len;
  endfunction

  // Letter m (0-based) of keyword id
  function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] m);
    logic [7:0] ch;
    ch = 8'd0;
    unique case (id)
      KW_TRUE: begin
        case (m)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'd0;
        endcase
      end
      KW_FALSE: begin
        case (m)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'd0;
        endcase
      end
      KW_NULL: begin
        case (m)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'd0;
        endcase
      end
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/json_token_lexer_core.sv
// ----------------------------------------------------------------------------
// json_token_lexer_core
// Streaming JSON lexer: one document byte in, punctuation/keyword/number/
// string/end/error tokens out.
// ----------------------------------------------------------------------------
// Input channel (in_*): one byte per item, in_tlast on the final byte of a
// document. Result channel (out_*): one token per item; out_tlast marks the
// last token caused by one input byte.
// Each accepted byte runs through the lexer step in the same cycle and its
// tokens (zero to three) are registered into a four-entry result queue; the
// first of them is offered on out_* once the tokens queued ahead have gone.
// Throughput is one byte per cycle while bytes yield at most one token and
// the receiver keeps up. in_tready is high while at most one token waits,
// so a byte that yields two or three tokens, or a stalled receiver, holds
// the input until the queue drains back to one entry.
// After an error token the remaining bytes of that document are taken and
// dropped without output; the byte marked last re-arms the lexer.
// Reset (rst_n low, synchronous) empties the queue and puts the lexer at
// offset zero between tokens.
// ----------------------------------------------------------------------------
module json_token_lexer_core #(
  parameter int unsigned MAX_DOC_BYTES = jtl_pkg::MAX_DOC_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // doc_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] token_kind, [19:4] token_start,
                                  // [35:20] token_length, [39:36] zero
  output logic        out_tlast   // run_last
);

  localparam int unsigned POS_W = $clog2(MAX_DOC_BYTES) + 1;
  localparam int unsigned CNT_W = $clog2(jtl_pkg::QDEPTH + 1);

  jtl_pkg::lex_state_t st_r, st_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    lstart_r, lstart_nxt;

  jtl_pkg::token_t [jtl_pkg::MAX_RES-1:0] res;
  logic [1:0]                             res_cnt;

  jtl_pkg::token_t [jtl_pkg::QDEPTH-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]                      q_cnt_r, q_cnt_nxt;

  logic             acc;
  logic             pop;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] nres;
  logic [CNT_W-1:0] off;

  jtl_step #(
    .MAX_DOC_BYTES(MAX_DOC_BYTES)
  ) u_step (
    .st_i     (st_r),
    .pos_i    (pos_r),
    .lstart_i (lstart_r),
    .c_i      (in_tdata),
    .last_i   (in_tlast),
    .st_o     (st_nxt),
    .pos_o    (pos_nxt),
    .lstart_o (lstart_nxt),
    .res_o    (res),
    .res_cnt_o(res_cnt)
  );

  assign in_tready  = (q_cnt_r <= CNT_W'(jtl_pkg::QDEPTH - jtl_pkg::MAX_RES));
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = (q_cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = {4'd0, q_r[0].length, q_r[0].start, 4'(q_r[0].kind)};
  assign out_tlast  = q_r[0].last;

  // Shift queue: head at entry 0, new tokens appended behind what survives the pop
  always_comb begin
    base  = q_cnt_r - CNT_W'(pop);
    nres  = acc ? CNT_W'(res_cnt) : '0;
    q_nxt = q_r;
    off   = '0;
    for (int j = 0; j < jtl_pkg::QDEPTH; j++) begin
      off = CNT_W'(j) - base;
      if (CNT_W'(j) < base) begin
        if (pop) begin
          q_nxt[j] = q_r[(j + 1 < jtl_pkg::QDEPTH) ? j + 1 : j];
        end
      end else if (off < nres) begin
        q_nxt[j] = res[off[1:0]];
      end
    end
    q_cnt_nxt = base + nres;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= jtl_pkg::LEX_STATE_RST;
      pos_r    <= '0;
      lstart_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (acc) begin
        st_r     <= st_nxt;
        pos_r    <= pos_nxt;
        lstart_r <= lstart_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  // Queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= CNT_W'(jtl_pkg::QDEPTH))
    else $error("result queue overflow");

  // A lone queued token always closes its byte's run
  a_lone_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (q_cnt_r == CNT_W'(1))) |-> out_tlast)
    else $error("single queued token without run_last");

  // Final byte re-arms the lexer
  a_doc_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |=> ((pos_r == '0) && (st_r.mode == jtl_pkg::M_IDLE) &&
                           !st_r.discarding))
    else $error("lexer not re-armed after last byte");

  // Dropped bytes add no tokens
  a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && st_r.discarding) |=> (q_cnt_r <= $past(q_cnt_r)))
    else $error("token emitted while discarding");

endmodule

// File: rtl/jtl_step.sv
// ----------------------------------------------------------------------------
// jtl_step
// Per-byte lexer step: next state and the up to three tokens one byte yields.
// ----------------------------------------------------------------------------
module jtl_step #(
  parameter int unsigned MAX_DOC_BYTES = jtl_pkg::MAX_DOC_BYTES_DEF
) (
  input  jtl_pkg::lex_state_t                         st_i,
  input  logic [$clog2(MAX_DOC_BYTES):0]              pos_i,
  input  logic [$clog2(MAX_DOC_BYTES):0]              lstart_i,
  input  logic [7:0]                                  c_i,
  input  logic                                        last_i,
  output jtl_pkg::lex_state_t                         st_o,
  output logic [$clog2(MAX_DOC_BYTES):0]              pos_o,
  output logic [$clog2(MAX_DOC_BYTES):0]              lstart_o,
  output jtl_pkg::token_t [jtl_pkg::MAX_RES-1:0]      res_o,
  output logic [1:0]                                  res_cnt_o
);

  localparam int unsigned POS_W = $clog2(MAX_DOC_BYTES) + 1;

  // Candidate slots in emit order: mode handling, redo as idle, finish, end
  localparam int unsigned NCAND = 4;

  jtl_pkg::token_t [NCAND-1:0] cand;
  logic [NCAND-1:0]            cand_v;
  logic                        failed;
  logic                        redo;
  logic [15:0]                 pos16;
  logic [1:0]                  kid;
  logic [2:0]                  klen;
  logic [2:0]                  km;
  logic [1:0]                  k;

  always_comb begin
    st_o     = st_i;
    pos_o    = pos_i;
    lstart_o = lstart_i;
    cand     = '0;
    cand_v   = '0;
    failed   = 1'b0;
    redo     = 1'b0;
    pos16    = 16'(pos_i);
    kid      = (st_i.kw_id < 2'd3) ? st_i.kw_id : jtl_pkg::KW_TRUE;
    klen     = jtl_pkg::kw_len(kid);
    km       = (st_i.kw_matched < klen) ? st_i.kw_matched : 3'd0;

    if (st_i.discarding) begin
      if (last_i) begin
        st_o     = jtl_pkg::LEX_STATE_RST;
        pos_o    = '0;
        lstart_o = '0;
      end
    end else begin
      if (pos_i >= POS_W'(MAX_DOC_BYTES)) begin
        cand_v[0]  = 1'b1;
        cand[0]    = '{kind: jtl_pkg::KIND_ERROR, start: pos16, length: 16'd0, last: 1'b0};
        st_o.mode  = jtl_pkg::M_IDLE;
        failed     = 1'b1;
      end else begin
        unique case (st_i.mode)
          jtl_pkg::M_INT: begin
            if (!jtl_pkg::is_digit(c_i)) begin
              if (c_i == ".") begin
                st_o.mode = jtl_pkg::M_DOT;
              end else if ((c_i == "e") || (c_i == "E")) begin
                st_o.mode = jtl_pkg::M_EXP;
              end else begin
                cand_v[0] = 1'b1;
                cand[0]   = '{kind: jtl_pkg::KIND_NUMBER, start: 16'(lstart_i),
                              length: pos16 - 16'(lstart_i), last: 1'b0};
                st_o.mode = jtl_pkg::M_IDLE;
                redo      = 1'b1;
              end
            end
          end
          jtl_pkg::M_DOT: begin
            if (jtl_pkg::is_digit(c_i)) begin
              st_o.mode = jtl_pkg::M_FRAC;
            end else begin
              cand_v[0] = 1'b1;
              cand[0]   = '{kind: jtl_pkg::KIND_ERROR, start: pos16, length: 16'd0, last: 1'b0};
              st_o.mode = jtl_pkg::M_IDLE;
              failed    = 1'b1;
            end
          end
          jtl_pkg::M_FRAC: begin
            if (!jtl_pkg::is_digit(c_i)) begin
              if ((c_i == "e") || (c_i == "E")) begin
                st_o.mode = jtl_pkg::M_EXP;
              end else begin
                cand_v[0] = 1'b1;
                cand[0]   = '{kind: jtl_pkg::KIND_NUMBER, start: 16'(lstart_i),
                              length: pos16 - 16'(lstart_i), last: 1'b0};
                st_o.mode = jtl_pkg::M_IDLE;
                redo      = 1'b1;
              end
            end
          end
          jtl_pkg::M_EXP: begin
            if ((c_i == "+") || (c_i == "-") || jtl_pkg::is_digit(c_i)) begin
              st_o.mode = jtl_pkg::M_EXPD;
            end else begin
              cand_v[0] = 1'b1;
              cand[0]   = '{kind: jtl_pkg::KIND_ERROR, start: pos16, length: 16'd0, last: 1'b0};
              st_o.mode = jtl_pkg::M_IDLE;
              failed    = 1'b1;
            end
          end
          jtl_pkg::M_EXPD: begin
            if (!jtl_pkg::is_digit(c_i)) begin
              cand_v[0] = 1'b1;
              cand[0]   = '{kind: jtl_pkg::KIND_NUMBER, start: 16'(lstart_i),
                            length: pos16 - 16'(lstart_i), last: 1'b0};
              st_o.mode = jtl_pkg::M_IDLE;
              redo      = 1'b1;
            end
          end
          jtl_pkg::M_KW: begin
            if ((km != 3'd0) && (c_i == jtl_pkg::kw_char(kid, km))) begin
              st_o.kw_matched = km + 3'd1;
              if ((km + 3'd1) == klen) begin
                cand_v[0] = 1'b1;
                cand[0]   = '{kind: jtl_pkg::kind_t'(4'(jtl_pkg::KIND_TRUE) + 4'(kid)),
                              start: pos16 + 16'd1 - 16'(klen),
                              length: 16'(klen), last: 1'b0};
                st_o.mode       = jtl_pkg::M_IDLE;
                st_o.kw_matched = 3'd0;
              end
            end else begin
              cand_v[0] = 1'b1;
              cand[0]   = '{kind: jtl_pkg::KIND_ERROR, start: pos16, length: 16'd0, last: 1'b0};
              st_o.mode = jtl_pkg::M_IDLE;
              failed    = 1'b1;
            end
          end
          jtl_pkg::M_STR: begin
            if (c_i == "\"") begin
              cand_v[0] = 1'b1;
              cand[0]   = '{kind: jtl_pkg::KIND_STRING, start: 16'(lstart_i),
                            length: pos16 - 16'(lstart_i), last: 1'b0};
              st_o.mode = jtl_pkg::M_IDLE;
            end else if (c_i == "\\") begin
              st_o.mode = jtl_pkg::M_ESC;
            end
          end
          jtl_pkg::M_ESC: begin
            if (jtl_pkg::is_simple_escape(c_i)) begin
              st_o.mode = jtl_pkg::M_STR;
            end else if (c_i == "u") begin
              st_o.mode     = jtl_pkg::M_HEX;
              st_o.hex_left = 3'd4;
            end else begin
              cand_v[0] = 1'b1;
              cand[0]   = '{kind: jtl_pkg::KIND_ERROR, start: pos16, length: 16'd0, last: 1'b0};
              st_o.mode = jtl_pkg::M_IDLE;
              failed    = 1'b1;
            end
          end
          jtl_pkg::M_HEX: begin
            if (jtl_pkg::is_hex(c_i) && (st_i.hex_left != 3'd0)) begin
              st_o.hex_left = st_i.hex_left - 3'd1;
              if (st_i.hex_left == 3'd1) begin
                st_o.mode = jtl_pkg::M_STR;
              end
            end else begin
              cand_v[0] = 1'b1;
              cand[0]   = '{kind: jtl_pkg::KIND_ERROR, start: pos16, length: 16'd0, last: 1'b0};
              st_o.mode = jtl_pkg::M_IDLE;
              failed    = 1'b1;
            end
          end
          default: begin
            st_o.mode = jtl_pkg::M_IDLE;
            redo      = 1'b1;
          end
        endcase

        // Byte lexed as the first byte of a new token
        if (redo) begin
          unique case (c_i)
            "{", "}", "[", "]", ":", ",": begin
              cand_v[1] = 1'b1;
              cand[1].start  = pos16;
              cand[1].length = 16'd1;
              case (c_i)
                "{":     cand[1].kind = jtl_pkg::KIND_LBRACE;
                "}":     cand[1].kind = jtl_pkg::KIND_RBRACE;
                "[":     cand[1].kind = jtl_pkg::KIND_LBRACKET;
                "]":     cand[1].kind = jtl_pkg::KIND_RBRACKET;
                ":":     cand[1].kind = jtl_pkg::KIND_COLON;
                default: cand[1].kind = jtl_pkg::KIND_COMMA;
              endcase
            end
            "t", "f", "n": begin
              st_o.mode       = jtl_pkg::M_KW;
              st_o.kw_matched = 3'd1;
              case (c_i)
                "t":     st_o.kw_id = jtl_pkg::KW_TRUE;
                "f":     st_o.kw_id = jtl_pkg::KW_FALSE;
                default: st_o.kw_id = jtl_pkg::KW_NULL;
              endcase
            end
            "\"": begin
              st_o.mode = jtl_pkg::M_STR;
              lstart_o  = pos_i + POS_W'(1);
            end
            default: begin
              if (jtl_pkg::is_space(c_i)) begin
                st_o.mode = jtl_pkg::M_IDLE;
              end else if ((c_i == "-") || jtl_pkg::is_digit(c_i)) begin
                st_o.mode = jtl_pkg::M_INT;
                lstart_o  = pos_i;
              end else begin
                cand_v[1] = 1'b1;
                cand[1]   = '{kind: jtl_pkg::KIND_ERROR, start: pos16, length: 16'd0,
                              last: 1'b0};
                st_o.mode = jtl_pkg::M_IDLE;
                failed    = 1'b1;
              end
            end
          endcase
        end
      end

      // End of document: close an open number, flag anything else unfinished
      if (last_i && !failed) begin
        if ((st_o.mode == jtl_pkg::M_INT) || (st_o.mode == jtl_pkg::M_FRAC) ||
            (st_o.mode == jtl_pkg::M_EXPD)) begin
          cand_v[2] = 1'b1;
          cand[2]   = '{kind: jtl_pkg::KIND_NUMBER, start: 16'(lstart_o),
                        length: pos16 + 16'd1 - 16'(lstart_o), last: 1'b0};
        end else if (st_o.mode != jtl_pkg::M_IDLE) begin
          cand_v[2] = 1'b1;
          cand[2]   = '{kind: jtl_pkg::KIND_ERROR, start: pos16, length: 16'd0, last: 1'b0};
          failed    = 1'b1;
        end
        if (!failed) begin
          cand_v[3] = 1'b1;
          cand[3]   = '{kind: jtl_pkg::KIND_END, start: pos16, length: 16'd0, last: 1'b0};
        end
      end

      if (failed) begin
        st_o.discarding = 1'b1;
      end
      if (last_i) begin
        st_o     = jtl_pkg::LEX_STATE_RST;
        pos_o    = '0;
        lstart_o = '0;
      end else begin
        pos_o = pos_i + POS_W'(1);
      end
    end
  end

  // Pack the candidates into consecutive result slots
  always_comb begin
    res_o = '0;
    k     = 2'd0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_v[i] && (k < 2'(jtl_pkg::MAX_RES))) begin
        res_o[k] = cand[i];
        k        = k + 2'd1;
      end
    end
    if (k != 2'd0) begin
      res_o[k - 2'd1].last = 1'b1;
    end
    res_cnt_o = k;
  end

endmodule
